@@ sv/s5mn_pkg.sv @@
// package for the socks5 method negotiation parser
// beat types, protocol constants, result codes; no dependencies
package s5mn_pkg;

   localparam logic [7:0] SOCKS_VERSION   = 8'h05;
   localparam logic [7:0] METHOD_NOAUTH   = 8'h00;
   localparam logic [7:0] METHOD_USERPASS = 8'h02;

   localparam logic [1:0] STATUS_REPLY       = 2'd0;
   localparam logic [1:0] STATUS_BAD_VERSION = 2'd1;
   localparam logic [1:0] STATUS_ZERO_COUNT  = 2'd2;
   localparam logic [1:0] STATUS_NO_METHOD   = 2'd3;

   // result queue depth, must be a power of two and at least 2
   localparam int RSP_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic [1:0] status;
      logic       next_is_auth;
      logic       last;
   } rsp_type;

   // what one parsed byte produces: zero, one or two result beats
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } parse_out_type;

endpackage

@@ sv/s5mn_parser.sv @@
// greeting parser: phase, method counter and offer flags, one byte per beat
// depends on s5mn_pkg
module s5mn_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  s5mn_pkg::req_type       item,
   output s5mn_pkg::parse_out_type result
);
   import s5mn_pkg::*;

   localparam logic [1:0] PH_VERSION = 2'd0;
   localparam logic [1:0] PH_COUNT   = 2'd1;
   localparam logic [1:0] PH_METHODS = 2'd2;
   localparam logic [1:0] PH_DONE    = 2'd3;

   logic [1:0] phase_ff, phase_in, phase_cur;
   logic [7:0] methods_left_ff, methods_left_in, methods_left_cur, methods_dec;
   logic       saw_userpass_ff, saw_userpass_in, saw_userpass_cur;
   logic       saw_noauth_ff, saw_noauth_in, saw_noauth_cur;

   always_comb begin
      // restart makes this byte the version byte of a fresh greeting
      phase_cur        = item.restart ? PH_VERSION : phase_ff;
      methods_left_cur = item.restart ? 8'd0 : methods_left_ff;
      saw_userpass_cur = item.restart ? 1'b0 : saw_userpass_ff;
      saw_noauth_cur   = item.restart ? 1'b0 : saw_noauth_ff;
      methods_dec      = methods_left_cur - 8'd1;

      phase_in        = phase_cur;
      methods_left_in = methods_left_cur;
      saw_userpass_in = saw_userpass_cur;
      saw_noauth_in   = saw_noauth_cur;
      result          = '0;

      unique case (phase_cur)
         PH_VERSION: begin
            if (item.in_byte != SOCKS_VERSION) begin
               phase_in            = PH_DONE;
               result.count        = 2'd1;
               result.first.status = STATUS_BAD_VERSION;
               result.first.last   = 1'b1;
            end else begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            if (item.in_byte == 8'd0) begin
               phase_in            = PH_DONE;
               result.count        = 2'd1;
               result.first.status = STATUS_ZERO_COUNT;
               result.first.last   = 1'b1;
            end else begin
               methods_left_in = item.in_byte;
               saw_userpass_in = 1'b0;
               saw_noauth_in   = 1'b0;
               phase_in        = PH_METHODS;
            end
         end
         PH_METHODS: begin
            saw_userpass_in = saw_userpass_cur | (item.in_byte == METHOD_USERPASS);
            saw_noauth_in   = saw_noauth_cur | (item.in_byte == METHOD_NOAUTH);
            methods_left_in = methods_dec;
            if (methods_dec == 8'd0) begin
               phase_in = PH_DONE;
               if (saw_userpass_in) begin
                  result.count              = 2'd2;
                  result.first.reply_byte   = SOCKS_VERSION;
                  result.first.status       = STATUS_REPLY;
                  result.first.next_is_auth = 1'b1;
                  result.second.reply_byte  = METHOD_USERPASS;
                  result.second.status      = STATUS_REPLY;
                  result.second.next_is_auth = 1'b1;
                  result.second.last        = 1'b1;
               end else if (saw_noauth_in) begin
                  result.count             = 2'd2;
                  result.first.reply_byte  = SOCKS_VERSION;
                  result.first.status      = STATUS_REPLY;
                  result.second.reply_byte = METHOD_NOAUTH;
                  result.second.status     = STATUS_REPLY;
                  result.second.last       = 1'b1;
               end else begin
                  result.count        = 2'd1;
                  result.first.status = STATUS_NO_METHOD;
                  result.first.last   = 1'b1;
               end
            end
         end
         PH_DONE: begin
            // ignoring until restart
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_VERSION;
         methods_left_ff <= 8'd0;
         saw_userpass_ff <= 1'b0;
         saw_noauth_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         methods_left_ff <= methods_left_in;
         saw_userpass_ff <= saw_userpass_in;
         saw_noauth_ff   <= saw_noauth_in;
      end
   end

endmodule

@@ sv/socks5_method_negotiation_parser.sv @@
// top level of the socks5 method negotiation parser
// input register, s5mn_parser, result queue; depends on s5mn_pkg
//
//  channel  | ports                          | beat
//  ---------+--------------------------------+-------------------------------
//  request  | req_valid req_ready req_data   | one greeting byte + restart
//  response | rsp_valid rsp_ready rsp_data   | one reply byte or error result
//
// a byte is parsed out of the input register, one byte per cycle while the result queue has room
// the parser writes zero, one or two result beats into a small result queue;
// a byte leaves the input register only when the queue has two free slots
// a stalled response side fills the queue, then req_ready drops
// synchronous reset empties the input register and queue and sets the
// parser to expect a version byte
module socks5_method_negotiation_parser #(
   parameter int QueueDepth = s5mn_pkg::RSP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  s5mn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output s5mn_pkg::rsp_type rsp_data
);
   import s5mn_pkg::*;

   localparam int PtrBits   = $clog2(QueueDepth);
   localparam int CountBits = $clog2(QueueDepth + 1);
   localparam logic [CountBits-1:0] SpaceLimit = CountBits'(QueueDepth - 2);

   // input register
   logic          stage_valid_ff, stage_valid_in;
   req_type       stage_data_ff;
   logic          stage_move;
   logic          req_fire;

   // result queue, plain flops
   rsp_type                queue_ff [QueueDepth];
   logic [PtrBits-1:0]     head_ff, head_in;
   logic [PtrBits-1:0]     tail_ff, tail_in;
   logic [CountBits-1:0]   count_ff, count_in;
   logic                   rsp_fire;

   parse_out_type          parsed;
   logic [PtrBits-1:0]     tail_next;

   // room for two beats, judged before this cycle's pop
   assign stage_move = stage_valid_ff && (count_ff <= SpaceLimit);
   assign req_ready  = !stage_valid_ff || stage_move;
   assign req_fire   = req_valid && req_ready;
   assign stage_valid_in = req_fire || (stage_valid_ff && !stage_move);

   s5mn_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (stage_move),
      .item   (stage_data_ff),
      .result (parsed)
   );

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[head_ff];
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign tail_next = tail_ff + PtrBits'(1);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (rsp_fire) begin
         head_in  = head_ff + PtrBits'(1);
         count_in = count_in - CountBits'(1);
      end
      if (stage_move) begin
         tail_in  = tail_ff + PtrBits'(parsed.count);
         count_in = count_in + CountBits'(parsed.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_data_ff <= req_data;
      end
      if (stage_move && (parsed.count != 2'd0)) begin
         queue_ff[tail_ff] <= parsed.first;
      end
      if (stage_move && (parsed.count == 2'd2)) begin
         queue_ff[tail_next] <= parsed.second;
      end
   end

endmodule

@@ verif/tb.sv @@
// testbench for socks5_method_negotiation_parser: greeting bytes in, reply beats out
// a directed table and then random greetings, checked against a local parser model
// depends on s5mn_pkg and the rtl top level only
`timescale 1ns / 100ps

module tb;
   import s5mn_pkg::*;

   // parser progress through one greeting
   typedef enum logic [1:0] {
      AWAIT_VERSION,
      AWAIT_COUNT,
      AWAIT_METHODS,
      GREETING_DONE
   } greet_phase_type;

   // one row of the directed table; typed rows carry their own expected beats,
   // the rest are left to the parser model
   typedef struct packed {
      req_type    beat;
      logic       typed;
      logic [1:0] n_rsp;
      rsp_type    first;
      rsp_type    second;
   } greet_row_type;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_BEATS = 650;
   localparam int IDLE_PERCENT = 14;

   localparam rsp_type NO_RSP        = '0;
   localparam rsp_type ERR_VERSION   = '{8'h00, STATUS_BAD_VERSION, 1'b0, 1'b1};
   localparam rsp_type ERR_COUNT     = '{8'h00, STATUS_ZERO_COUNT, 1'b0, 1'b1};
   localparam rsp_type ERR_NO_METHOD = '{8'h00, STATUS_NO_METHOD, 1'b0, 1'b1};
   localparam rsp_type UP_HEAD       = '{SOCKS_VERSION, STATUS_REPLY, 1'b1, 1'b0};
   localparam rsp_type UP_TAIL       = '{METHOD_USERPASS, STATUS_REPLY, 1'b1, 1'b1};
   localparam rsp_type NA_HEAD       = '{SOCKS_VERSION, STATUS_REPLY, 1'b0, 1'b0};
   localparam rsp_type NA_TAIL       = '{METHOD_NOAUTH, STATUS_REPLY, 1'b0, 1'b1};

   localparam int DIR_ROWS = 25;
   localparam greet_row_type GREETING_TABLE [DIR_ROWS] = '{
      // straight out of reset the first byte is a version byte without restart
      '{'{SOCKS_VERSION, 1'b0}, 1'b1, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h01, 1'b0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{METHOD_USERPASS, 1'b0}, 1'b1, 2'd2, UP_HEAD, UP_TAIL},
      // finished, so this byte is dropped
      '{'{8'hAA, 1'b0}, 1'b1, 2'd0, NO_RSP, NO_RSP},
      // bad version, then junk after the error
      '{'{8'h04, 1'b1}, 1'b1, 2'd1, ERR_VERSION, NO_RSP},
      '{'{8'hFF, 1'b0}, 1'b1, 2'd0, NO_RSP, NO_RSP},
      // zero method count
      '{'{SOCKS_VERSION, 1'b1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h00, 1'b0}, 1'b1, 2'd1, ERR_COUNT, NO_RSP},
      // no-auth as the fallback among unknown codes
      '{'{SOCKS_VERSION, 1'b1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h03, 1'b0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h01, 1'b0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{METHOD_NOAUTH, 1'b0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'hFF, 1'b0}, 1'b1, 2'd2, NA_HEAD, NA_TAIL},
      // username/password wins over no-auth offered first
      '{'{SOCKS_VERSION, 1'b1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h02, 1'b0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{METHOD_NOAUTH, 1'b0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{METHOD_USERPASS, 1'b0}, 1'b1, 2'd2, UP_HEAD, UP_TAIL},
      // nothing acceptable offered
      '{'{SOCKS_VERSION, 1'b1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h01, 1'b0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h80, 1'b0}, 1'b1, 2'd1, ERR_NO_METHOD, NO_RSP},
      // restart in the middle of a method list
      '{'{SOCKS_VERSION, 1'b1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h04, 1'b0}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{SOCKS_VERSION, 1'b1}, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{'{8'h00, 1'b0}, 1'b1, 2'd1, ERR_COUNT, NO_RSP},
      // restart carrying a zero version byte
      '{'{8'h00, 1'b1}, 1'b1, 2'd1, ERR_VERSION, NO_RSP}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // parser model state
   greet_phase_type greet_phase;
   logic [7:0]      methods_left;
   logic            saw_userpass;
   logic            saw_noauth;

   rsp_type expected_replies [$];
   int      bad_results;
   int      parsed_beats;
   int      quiet_cycles;
   logic    idle_on;

   socks5_method_negotiation_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // next state and reply beats of the parser for one byte
   task automatic predict_reply(input req_type beat, output int n,
                                output rsp_type first, output rsp_type second);
      n      = 0;
      first  = NO_RSP;
      second = NO_RSP;
      if (beat.restart) begin
         greet_phase  = AWAIT_VERSION;
         methods_left = 8'd0;
         saw_userpass = 1'b0;
         saw_noauth   = 1'b0;
      end
      case (greet_phase)
         AWAIT_VERSION: begin
            if (beat.in_byte != SOCKS_VERSION) begin
               greet_phase = GREETING_DONE;
               n           = 1;
               first       = ERR_VERSION;
            end else begin
               greet_phase = AWAIT_COUNT;
            end
         end
         AWAIT_COUNT: begin
            if (beat.in_byte == 8'd0) begin
               greet_phase = GREETING_DONE;
               n           = 1;
               first       = ERR_COUNT;
            end else begin
               methods_left = beat.in_byte;
               saw_userpass = 1'b0;
               saw_noauth   = 1'b0;
               greet_phase  = AWAIT_METHODS;
            end
         end
         AWAIT_METHODS: begin
            if (beat.in_byte == METHOD_USERPASS) saw_userpass = 1'b1;
            else if (beat.in_byte == METHOD_NOAUTH) saw_noauth = 1'b1;
            methods_left = methods_left - 8'd1;
            // the reply goes out on the last method byte only
            if (methods_left == 8'd0) begin
               greet_phase = GREETING_DONE;
               if (saw_userpass) begin
                  n      = 2;
                  first  = '{SOCKS_VERSION, STATUS_REPLY, 1'b1, 1'b0};
                  second = '{METHOD_USERPASS, STATUS_REPLY, 1'b1, 1'b1};
               end else if (saw_noauth) begin
                  n      = 2;
                  first  = '{SOCKS_VERSION, STATUS_REPLY, 1'b0, 1'b0};
                  second = '{METHOD_NOAUTH, STATUS_REPLY, 1'b0, 1'b1};
               end else begin
                  n     = 1;
                  first = ERR_NO_METHOD;
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic greet_row_type plain_beat(input logic [7:0] value,
                                                input logic restart);
      greet_row_type row;
      row             = '0;
      row.beat.in_byte = value;
      row.beat.restart = restart;
      return row;
   endfunction

   // offer one beat, wait for the handshake, then queue what it should produce
   task automatic send_beat(input greet_row_type row);
      logic    took;
      int      n_pred;
      rsp_type pred_first;
      rsp_type pred_second;
      // a stretch of the run goes without any idling at all
      idle_on = !(parsed_beats >= 300 && parsed_beats < 400);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row.beat;
      took = 1'b0;
      // ready is settled by the falling edge, the beat goes at the next rising one
      while (!took) begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end
      if (row.beat.restart || greet_phase != GREETING_DONE) parsed_beats++;
      predict_reply(row.beat, n_pred, pred_first, pred_second);
      if (row.typed) begin
         if (row.n_rsp >= 2'd1) expected_replies.push_back(row.first);
         if (row.n_rsp == 2'd2) expected_replies.push_back(row.second);
      end else begin
         if (n_pred >= 1) expected_replies.push_back(pred_first);
         if (n_pred == 2) expected_replies.push_back(pred_second);
      end
   endtask

   function automatic logic [7:0] pick_method(input logic allow_up, input logic allow_na);
      logic [7:0] code;
      int         roll;
      roll = $urandom_range(0, 3);
      if (roll == 0 && allow_up) return METHOD_USERPASS;
      if (roll == 1 && allow_na) return METHOD_NOAUTH;
      code = 8'($urandom_range(0, 255));
      // steer clear of the two codes the parser cares about
      if (code == METHOD_NOAUTH || code == METHOD_USERPASS) code = code | 8'h80;
      return code;
   endfunction

   // well-formed greeting head, then 'cut' of its 'count' method bytes
   task automatic send_greeting(input logic [7:0] count, input int cut);
      logic allow_up;
      logic allow_na;
      allow_up = 1'($urandom_range(0, 1));
      allow_na = 1'($urandom_range(0, 1));
      send_beat(plain_beat(SOCKS_VERSION, 1'b1));
      send_beat(plain_beat(count, 1'b0));
      for (int i = 0; i < cut; i++) send_beat(plain_beat(pick_method(allow_up, allow_na), 1'b0));
   endtask

   // result side stalls at random, except in the quiet stretch
   always @(posedge clock) begin
      rsp_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
   end

   // compare each reply beat with the oldest expectation; watchdog on no progress
   always @(negedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %s %h %s %0d %s %0b %s %0b",
                        $time, "byte", rsp_data.reply_byte, "status", rsp_data.status,
                        "auth", rsp_data.next_is_auth, "last", rsp_data.last);
               bad_results++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: reply mismatch, expected byte %h status %0d auth %0b last %0b",
                           $time, want.reply_byte, want.status, want.next_is_auth, want.last);
                  $display("%0t: reply mismatch, actual   byte %h status %0d auth %0b last %0b",
                           $time, rsp_data.reply_byte, rsp_data.status,
                           rsp_data.next_is_auth, rsp_data.last);
                  bad_results++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] count;
      logic [7:0] value;
      int         kind;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      idle_on      = 1'b1;
      bad_results  = 0;
      parsed_beats = 0;
      quiet_cycles = 0;
      greet_phase  = AWAIT_VERSION;
      methods_left = 8'd0;
      saw_userpass = 1'b0;
      saw_noauth   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIR_ROWS; i++) send_beat(GREETING_TABLE[i]);

      // longest method list once, then mostly short greetings
      parsed_beats = 0;
      send_greeting(8'hFF, 255);
      while (parsed_beats < RANDOM_BEATS) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            count = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(16, 64))
                                                 : 8'($urandom_range(1, 6));
            send_greeting(count, count);
         end else if (kind < 85) begin
            // greeting cut short, the next restart abandons it
            count = 8'($urandom_range(2, 8));
            send_greeting(count, $urandom_range(0, count - 1));
         end else if (kind < 90) begin
            value = 8'($urandom_range(0, 255));
            if (value == SOCKS_VERSION) value = 8'h85;
            send_beat(plain_beat(value, 1'b1));
         end else if (kind < 94) begin
            send_beat(plain_beat(SOCKS_VERSION, 1'b1));
            send_beat(plain_beat(8'h00, 1'b0));
         end else begin
            // loose bytes, now and then with a restart among them
            repeat ($urandom_range(1, 4))
               send_beat(plain_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
         end
      end
      req_valid <= 1'b0;

      // drain, then give stray beats a chance to show up
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_results == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/s5mn_pkg.sv
sv/s5mn_parser.sv
sv/socks5_method_negotiation_parser.sv
verif/tb.sv
